>>> rtl/dfare_pkg.sv
package dfare_pkg;

  // Parse phases, one-hot
  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_QNAME  = 7'b0000010,
    PH_QTAIL  = 7'b0000100,
    PH_ANAME  = 7'b0001000,
    PH_AFIXED = 7'b0010000,
    PH_ADATA  = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  // DNS framing constants
  localparam logic [3:0]  HDR_QD_HI     = 4'd4;
  localparam logic [3:0]  HDR_QD_LO     = 4'd5;
  localparam logic [3:0]  HDR_AN_HI     = 4'd6;
  localparam logic [3:0]  HDR_AN_LO     = 4'd7;
  localparam logic [3:0]  HDR_LAST      = 4'd11;
  localparam logic [3:0]  FIX_TYPE_LAST = 4'd1;
  localparam logic [3:0]  FIX_LEN_FIRST = 4'd8;
  localparam logic [3:0]  FIX_LAST      = 4'd9;
  localparam logic [3:0]  POS_PENDING   = 4'd1;
  localparam logic [15:0] QTAIL_BYTES   = 16'd4;
  localparam logic [15:0] TYPE_A        = 16'd1;
  localparam logic [15:0] ADDR_BYTES    = 16'd4;
  localparam logic [1:0]  PTR_MARK      = 2'b11;

  // One finished result
  typedef struct packed {
    logic [31:0] addr;
    logic        found;
  } result_t;

endpackage

>>> rtl/dfare_parser.sv
module dfare_parser
  import dfare_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       consume,
  input  logic [7:0] byte_in,
  input  logic       eop,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [3:0]  fpos, fpos_next;
  logic [15:0] qleft, qleft_next;
  logic [15:0] aleft, aleft_next;
  logic [15:0] skip, skip_next;
  logic [15:0] rtype, rtype_next;
  logic [15:0] rlen, rlen_next;
  logic [31:0] addr, addr_next;
  logic        found, found_next;

  // name walker, shared by question and answer names
  logic        name_done;
  logic [3:0]  name_fpos;
  logic [15:0] name_skip;
  logic [15:0] skip_dec;

  assign skip_dec = skip - 16'd1;

  function automatic phase_t section_after(input logic [15:0] q, input logic [15:0] a);
    phase_t p;
    if (q != '0) p = PH_QNAME;
    else if (a != '0) p = PH_ANAME;
    else p = PH_DONE;
    return p;
  endfunction

  always_comb begin
    name_done = 1'b0;
    name_fpos = fpos;
    name_skip = skip;
    if (fpos == POS_PENDING) begin
      // second byte of a compression pointer
      name_done = 1'b1;
      name_fpos = '0;
    end else if (skip != '0) begin
      name_skip = skip_dec;
    end else if (byte_in == '0) begin
      name_done = 1'b1;
    end else if (byte_in[7:6] == PTR_MARK) begin
      name_fpos = POS_PENDING;
    end else begin
      name_skip = {8'd0, byte_in};
    end
  end

  // per-byte next state
  always_comb begin
    phase_next = phase;
    fpos_next  = fpos;
    qleft_next = qleft;
    aleft_next = aleft;
    skip_next  = skip;
    rtype_next = rtype;
    rlen_next  = rlen;
    addr_next  = addr;
    found_next = found;
    case (phase)
      PH_HEADER: begin
        if (fpos == HDR_QD_HI || fpos == HDR_QD_LO) begin
          qleft_next = {qleft[7:0], byte_in};
        end else if (fpos == HDR_AN_HI || fpos == HDR_AN_LO) begin
          aleft_next = {aleft[7:0], byte_in};
        end
        if (fpos >= HDR_LAST) begin
          phase_next = section_after(qleft_next, aleft_next);
          fpos_next  = '0;
          skip_next  = '0;
        end else begin
          fpos_next = fpos + 4'd1;
        end
      end
      PH_QNAME: begin
        if (name_done) begin
          phase_next = PH_QTAIL;
          skip_next  = QTAIL_BYTES;
          fpos_next  = '0;
        end else begin
          fpos_next = name_fpos;
          skip_next = name_skip;
        end
      end
      PH_QTAIL: begin
        skip_next = skip_dec;
        if (skip_dec == '0) begin
          qleft_next = qleft - 16'd1;
          phase_next = section_after(qleft_next, aleft);
          fpos_next  = '0;
          skip_next  = '0;
        end
      end
      PH_ANAME: begin
        if (name_done) begin
          phase_next = PH_AFIXED;
          fpos_next  = '0;
          skip_next  = '0;
        end else begin
          fpos_next = name_fpos;
          skip_next = name_skip;
        end
      end
      PH_AFIXED: begin
        if (fpos <= FIX_TYPE_LAST) begin
          rtype_next = {rtype[7:0], byte_in};
        end else if (fpos >= FIX_LEN_FIRST) begin
          rlen_next = {rlen[7:0], byte_in};
        end
        if (fpos >= FIX_LAST) begin
          phase_next = PH_ADATA;
          if (rtype_next == TYPE_A && rlen_next == ADDR_BYTES) begin
            fpos_next = POS_PENDING;
            skip_next = ADDR_BYTES;
          end else begin
            fpos_next = '0;
            skip_next = rlen_next;
            if (rlen_next == '0) begin
              // empty data: record ends here
              aleft_next = aleft - 16'd1;
              phase_next = section_after(qleft, aleft_next);
            end
          end
        end else begin
          fpos_next = fpos + 4'd1;
        end
      end
      PH_ADATA: begin
        skip_next = skip_dec;
        if (fpos == POS_PENDING) begin
          addr_next = {addr[23:0], byte_in};
          if (skip_dec == '0) begin
            found_next = 1'b1;
            phase_next = PH_DONE;
            fpos_next  = '0;
          end
        end else if (skip_dec == '0) begin
          aleft_next = aleft - 16'd1;
          phase_next = section_after(qleft, aleft_next);
          fpos_next  = '0;
          skip_next  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // result for the end-marked byte
  assign result.found = found_next;
  assign result.addr  = found_next ? addr_next : '0;

  always_ff @(posedge clk) begin
    if (rst || (consume && eop)) begin
      phase <= PH_HEADER;
      fpos  <= '0;
      qleft <= '0;
      aleft <= '0;
      skip  <= '0;
      rtype <= '0;
      rlen  <= '0;
      addr  <= '0;
      found <= 1'b0;
    end else if (consume) begin
      phase <= phase_next;
      fpos  <= fpos_next;
      qleft <= qleft_next;
      aleft <= aleft_next;
      skip  <= skip_next;
      rtype <= rtype_next;
      rlen  <= rlen_next;
      addr  <= addr_next;
      found <= found_next;
    end
  end

endmodule

>>> rtl/dfare_out_stage.sv
module dfare_out_stage
  import dfare_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  output logic        free,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] ipv4_address,
  output logic        address_found
);

  // slot can take a new result when empty or being drained this cycle
  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ipv4_address  <= result.addr;
      address_found <= result.found;
    end
  end

endmodule

>>> rtl/dns_first_a_record_extractor.sv
// Streams a DNS response in one byte per transaction (end_of_packet on the
// last byte) and, for every packet, returns one result transaction holding
// the address of the first A record with data length 4, or 0 with
// address_found low if there is none or the packet was cut short. A byte is
// accepted every cycle; each byte goes through an input register and the
// combinational parse logic, and the last byte also loads the result
// register, which presents the result. Input stalls only while a result
// is held with result_ready low and the next end-marked byte needs the
// result register.
module dns_first_a_record_extractor
  import dfare_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        packet_valid,
  output logic        packet_ready,
  input  logic [7:0]  packet_byte,
  input  logic        end_of_packet,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] ipv4_address,
  output logic        address_found
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eop;
  logic       advance;
  logic       out_free;
  result_t    result;

  // byte leaves the input register unless it closes a packet and the
  // result slot is occupied
  assign advance      = in_valid && (!in_eop || out_free);
  assign packet_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (packet_ready) begin
      in_valid <= packet_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (packet_ready && packet_valid) begin
      in_byte <= packet_byte;
      in_eop  <= end_of_packet;
    end
  end

  dfare_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .consume (advance),
    .byte_in (in_byte),
    .eop     (in_eop),
    .result  (result)
  );

  dfare_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && in_eop),
    .result        (result),
    .free          (out_free),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .ipv4_address  (ipv4_address),
    .address_found (address_found)
  );

  // a not-found result always carries a zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    result_valid && !address_found |-> ipv4_address == '0)
    else $error("not-found result with nonzero address");

  // held end byte must stall input while the result slot is blocked
  a_stall_on_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_eop && result_valid && !result_ready |-> !packet_ready)
    else $error("input accepted while end byte is blocked");

  // reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !in_valid)
    else $error("pipeline not empty after reset");

endmodule

>>> verif/dns_first_a_record_extractor_test.sv
module dns_first_a_record_extractor_test;
  import dfare_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int TAIL_CYCLES   = 16;
  localparam int MIN_BYTES     = 1150;
  localparam int MIN_PACKETS   = 40;
  localparam int DRAIN_PACKET  = 20;
  localparam int HOLD_AT_RESULT = 3;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;

  // One byte of a packet waiting to be sent
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;  // wait for all results before sending this one
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        packet_valid = 1'b0;
  logic        packet_ready;
  logic [7:0]  packet_byte = 8'h00;
  logic        end_of_packet = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] ipv4_address;
  logic        address_found;

  byte_item_t  pending_bytes[$];
  result_t     expected_results[$];
  logic [7:0]  pkt_bytes[$];

  int cycle_count = 0;
  int error_count = 0;
  int results_seen = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int long_hold = 0;
  bit hold_done = 1'b0;

  // Parser state mirrored by the predictor
  phase_t      prs_phase;
  logic [3:0]  prs_pos;
  logic [15:0] prs_questions;
  logic [15:0] prs_answers;
  logic [15:0] prs_skip;
  logic [15:0] prs_type;
  logic [15:0] prs_rdlen;
  logic [31:0] prs_addr;
  logic        prs_found;

  dns_first_a_record_extractor i_dut (
    .clk           (clk),
    .rst           (rst),
    .packet_valid  (packet_valid),
    .packet_ready  (packet_ready),
    .packet_byte   (packet_byte),
    .end_of_packet (end_of_packet),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .ipv4_address  (ipv4_address),
    .address_found (address_found)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic void clear_parser();
    prs_phase     = PH_HEADER;
    prs_pos       = '0;
    prs_questions = '0;
    prs_answers   = '0;
    prs_skip      = '0;
    prs_type      = '0;
    prs_rdlen     = '0;
    prs_addr      = '0;
    prs_found     = 1'b0;
  endfunction

  function automatic void next_section();
    prs_pos  = '0;
    prs_skip = '0;
    if (prs_questions != 0) prs_phase = PH_QNAME;
    else if (prs_answers != 0) prs_phase = PH_ANAME;
    else prs_phase = PH_DONE;
  endfunction

  // One byte of a name; returns 1 when the name is complete
  function automatic bit walk_name(logic [7:0] b);
    if (prs_pos == POS_PENDING) begin
      prs_pos = '0;
      return 1'b1;
    end
    if (prs_skip != 0) begin
      prs_skip = prs_skip - 16'd1;
      return 1'b0;
    end
    if (b == 8'h00) return 1'b1;
    if (b[7:6] == PTR_MARK) prs_pos = POS_PENDING;
    else prs_skip = {8'h00, b};
    return 1'b0;
  endfunction

  function automatic void parse_dns_byte(logic [7:0] b, logic last);
    result_t res;
    case (prs_phase)
      PH_HEADER: begin
        if (prs_pos == HDR_QD_HI || prs_pos == HDR_QD_LO)
          prs_questions = {prs_questions[7:0], b};
        else if (prs_pos == HDR_AN_HI || prs_pos == HDR_AN_LO)
          prs_answers = {prs_answers[7:0], b};
        if (prs_pos >= HDR_LAST) next_section();
        else prs_pos = prs_pos + 4'd1;
      end
      PH_QNAME: begin
        if (walk_name(b)) begin
          prs_phase = PH_QTAIL;
          prs_skip  = QTAIL_BYTES;
          prs_pos   = '0;
        end
      end
      PH_QTAIL: begin
        prs_skip = prs_skip - 16'd1;
        if (prs_skip == 0) begin
          prs_questions = prs_questions - 16'd1;
          next_section();
        end
      end
      PH_ANAME: begin
        if (walk_name(b)) begin
          prs_phase = PH_AFIXED;
          prs_pos   = '0;
          prs_skip  = '0;
        end
      end
      PH_AFIXED: begin
        if (prs_pos <= FIX_TYPE_LAST) prs_type = {prs_type[7:0], b};
        else if (prs_pos >= FIX_LEN_FIRST) prs_rdlen = {prs_rdlen[7:0], b};
        if (prs_pos >= FIX_LAST) begin
          prs_phase = PH_ADATA;
          if (prs_type == TYPE_A && prs_rdlen == ADDR_BYTES) begin
            prs_pos  = POS_PENDING;
            prs_skip = ADDR_BYTES;
          end else begin
            prs_pos  = '0;
            prs_skip = prs_rdlen;
            if (prs_skip == 0) begin
              prs_answers = prs_answers - 16'd1;
              next_section();
            end
          end
        end else begin
          prs_pos = prs_pos + 4'd1;
        end
      end
      PH_ADATA: begin
        prs_skip = prs_skip - 16'd1;
        if (prs_pos == POS_PENDING) begin
          prs_addr = {prs_addr[23:0], b};
          if (prs_skip == 0) begin
            prs_found = 1'b1;
            prs_phase = PH_DONE;
            prs_pos   = '0;
          end
        end else if (prs_skip == 0) begin
          prs_answers = prs_answers - 16'd1;
          next_section();
        end
      end
      default: ;
    endcase
    if (last) begin
      res.addr  = prs_found ? prs_addr : 32'h0;
      res.found = prs_found;
      expected_results = {expected_results, res};
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Packet generation
  // ---------------------------------------------------------------------
  // Mostly short gaps, a few long ones, none during quiet stretches
  function automatic int pick_gap();
    if ((cycle_count % 1024) >= 768) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 7) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_random(int n);
    logic [7:0] v;
    repeat (n) begin
      v = 8'($urandom);
      pkt_bytes = {pkt_bytes, v};
    end
  endtask

  // Labels, then a zero byte or a compression pointer
  task automatic append_name();
    int         n_labels;
    int         len;
    logic [7:0] v;
    n_labels = $urandom_range(0, 3);
    repeat (n_labels) begin
      if ($urandom_range(0, 31) == 0) len = $urandom_range(64, 191);
      else len = $urandom_range(1, 8);
      v = 8'(len);
      pkt_bytes = {pkt_bytes, v};
      push_random(len);
    end
    if ($urandom_range(0, 1) != 0) begin
      v = {PTR_MARK, 6'($urandom)};
      pkt_bytes = {pkt_bytes, v};
      push_random(1);
    end else begin
      pkt_bytes = {pkt_bytes, 8'h00};
    end
  endtask

  task automatic add_packet(bit drain);
    logic [15:0] qd;
    logic [15:0] an;
    logic [15:0] typ;
    logic [15:0] rdlen;
    int          n_ans;
    int          cut;
    byte_item_t  item;
    pkt_bytes.delete();
    if ($urandom_range(0, 5) == 0) begin
      // noise
      push_random($urandom_range(1, 30));
    end else begin
      qd = 16'($urandom_range(0, 2));
      an = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 15) == 0) qd = 16'($urandom);
      if ($urandom_range(0, 15) == 0) an = 16'($urandom);
      push_random(4);
      pkt_bytes = {pkt_bytes, qd[15:8], qd[7:0], an[15:8], an[7:0]};
      push_random(4);
      for (int q = 0; q < int'(qd) && q < 3; q++) begin
        append_name();
        push_random(4);
      end
      n_ans = (an > 16'd4) ? 4 : int'(an);
      for (int a = 0; a < n_ans; a++) begin
        append_name();
        typ = ($urandom_range(0, 3) != 0) ? TYPE_A : 16'($urandom);
        pkt_bytes = {pkt_bytes, typ[15:8], typ[7:0]};
        push_random(6);
        if (typ == TYPE_A && $urandom_range(0, 3) != 0) rdlen = ADDR_BYTES;
        else rdlen = 16'($urandom_range(0, 6));
        pkt_bytes = {pkt_bytes, rdlen[15:8], rdlen[7:0]};
        push_random(int'(rdlen));
      end
      if ($urandom_range(0, 1) != 0) push_random($urandom_range(1, 3));
    end
    cut = pkt_bytes.size();
    if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, pkt_bytes.size());
    for (int i = 0; i < cut; i++) begin
      item.data  = pkt_bytes[i];
      item.last  = (i == cut - 1);
      item.drain = drain && (i == 0);
      pending_bytes = {pending_bytes, item};
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers queued bytes, predicts on every accepted transaction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : driver
    byte_item_t item;
    logic       offer;
    if (rst) begin
      packet_valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (packet_valid && packet_ready) parse_dns_byte(packet_byte, end_of_packet);
      if (!packet_valid || packet_ready) begin
        offer = 1'b0;
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_bytes.size() != 0 &&
                     (!pending_bytes[0].drain || expected_results.size() == 0)) begin
          item = pending_bytes.pop_front();
          packet_byte   <= item.data;
          end_of_packet <= item.last;
          offer = 1'b1;
          send_gap <= pick_gap();
        end
        packet_valid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks accepted results, drives result_ready
  // ---------------------------------------------------------------------
  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result: addr %08h found %0b",
                               ipv4_address, address_found));
        end else begin
          want = expected_results.pop_front();
          if (ipv4_address !== want.addr || address_found !== want.found)
            flag_error($sformatf("result mismatch: expected addr %08h found %0b, got addr %08h found %0b",
                                 want.addr, want.found, ipv4_address, address_found));
        end
      end
      if (long_hold != 0) begin
        result_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap     <= recv_gap - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        recv_gap     <= pick_gap();
      end
    end
  end

  // Long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin : stall_timer
    if (rst) begin
      long_hold <= 0;
      hold_done <= 1'b0;
    end else if (long_hold != 0) begin
      long_hold <= long_hold - 1;
    end else if (!hold_done && results_seen == HOLD_AT_RESULT) begin
      long_hold <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : main
    byte_item_t item;
    int         n_packets;
    clear_parser();
    item.drain = 1'b0;

    // Truncated in the header: a single end-marked byte
    item.data = 8'hFF;
    item.last = 1'b1;
    pending_bytes = {pending_bytes, item};

    // Both counts zero, then a byte ignored in the done phase
    for (int i = 0; i < 13; i++) begin
      item.data = (i >= 4 && i <= 7) ? 8'h00 : (i == 12 ? 8'h00 : 8'hFF);
      item.last = (i == 12);
      pending_bytes = {pending_bytes, item};
    end

    n_packets = 2;
    while (pending_bytes.size() < MIN_BYTES || n_packets < MIN_PACKETS) begin
      add_packet(n_packets == DRAIN_PACKET);
      n_packets++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || packet_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
